// ----- sv/zbpw_pkg.sv -----
package zbpw_pkg;

  // Default frame size
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // Field widths
  localparam int COORD_W = 11;
  localparam int COLOR_W = 16;
  localparam int DEPTH_W = 32;
  localparam int TRI_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TEX_W   = 16;
  localparam int RES_W   = 10;

  // Stream word widths
  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 104;

  // Configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 1'b1;
  localparam logic [RES_W-1:0] RES_RESET = 10'd512;

  // Store reset contents
  localparam logic [DEPTH_W-1:0] FAR_DEPTH   = 32'h7FFF_FFFF;
  localparam logic [COLOR_W-1:0] WHITE_LEVEL = 16'd4095;
  localparam logic [TRI_W-1:0]   NO_OWNER    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_PLAIN   = 2'd1,
    OP_TAG     = 2'd2,
    OP_TAG_TEX = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BACKGROUND = 2'd0,
    KIND_TEXTURED   = 2'd1,
    KIND_EDGE       = 2'd2,
    KIND_OTHER      = 2'd3
  } kind_t;

  // One stored pixel word
  typedef struct packed {
    logic [TEX_W-1:0]   texture;
    logic [KIND_W-1:0]  kind;
    logic [TRI_W-1:0]   owner;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] alpha;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  localparam int PIXEL_W = $bits(pixel_t);

  function automatic pixel_t reset_pixel();
    pixel_t p;
    p.texture = '0;
    p.kind    = KIND_BACKGROUND;
    p.owner   = NO_OWNER;
    p.depth   = FAR_DEPTH;
    p.alpha   = '0;
    p.blue    = WHITE_LEVEL;
    p.green   = WHITE_LEVEL;
    p.red     = WHITE_LEVEL;
    return p;
  endfunction

endpackage

// ----- sv/zbuffer_pixel_write_unit.sv -----
// An accepted word passes the access stage register, then the output register
// that drives out_tvalid. Throughput: one word per cycle while out_tready is
// high; the depth read-modify-write on the pixel memory forwards the last
// written pixel to a following access. Reset: rst_n is synchronous, active
// low; then the memory is cleared one entry per cycle, all MAX_WIDTH*MAX_HEIGHT
// (262144 by default), with in_tready low. Config writes are taken throughout.
module zbuffer_pixel_write_unit #(
  parameter int MAX_WIDTH  = zbpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbpw_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [zbpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [zbpw_pkg::RES_W-1:0]           cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // pixel_x, pixel_y, color_red, color_green, color_blue, color_alpha,
  // depth, triangle_id, texture_id, 2 zero bits
  input  logic [zbpw_pkg::IN_DATA_W-1:0]       in_tdata,
  // op, pixel_kind
  input  logic [zbpw_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status, written, read_red, read_green, read_blue, read_depth,
  // read_owner, 6 zero bits
  output logic [zbpw_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [zbpw_pkg::RES_W-1:0] width_r;
  logic [zbpw_pkg::RES_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= zbpw_pkg::RES_RESET;
      height_r <= zbpw_pkg::RES_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == zbpw_pkg::CFG_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == zbpw_pkg::CFG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Unpack the input word
  zbpw_pkg::op_t    in_op;
  zbpw_pkg::pixel_t in_frag;
  logic [zbpw_pkg::COORD_W-1:0] in_x;
  logic [zbpw_pkg::COORD_W-1:0] in_y;

  assign in_op           = zbpw_pkg::op_t'(in_tuser[1:0]);
  assign in_x            = in_tdata[10:0];
  assign in_y            = in_tdata[21:11];
  assign in_frag.red     = in_tdata[37:22];
  assign in_frag.green   = in_tdata[53:38];
  assign in_frag.blue    = in_tdata[69:54];
  assign in_frag.alpha   = in_tdata[85:70];
  assign in_frag.depth   = in_tdata[117:86];
  assign in_frag.owner   = in_tdata[133:118];
  assign in_frag.texture = in_tdata[149:134];
  assign in_frag.kind    = in_tuser[3:2];

  // Coordinate check and address
  logic              in_oor;
  logic [ADDR_W-1:0] in_addr;

  zbpw_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_addr (
    .pixel_x    (in_x),
    .pixel_y    (in_y),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .oor        (in_oor),
    .addr       (in_addr)
  );

  // Clearing sweep
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  zbpw_clear #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // Handshake
  logic in_fire;
  logic s1_adv;
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // Access stage: memory data arrives here
  zbpw_pkg::op_t     s1_op_r;
  logic              s1_oor_r;
  logic [ADDR_W-1:0] s1_addr_r;
  zbpw_pkg::pixel_t  s1_frag_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_oor_r  <= in_oor;
      s1_addr_r <= in_addr;
      s1_frag_r <= in_frag;
    end
  end

  // Pixel memory
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [zbpw_pkg::PIXEL_W-1:0]  ram_wdata;
  logic [zbpw_pkg::PIXEL_W-1:0]  ram_rdata;
  zbpw_pkg::pixel_t              new_pix;
  logic                          s1_wr;

  assign ram_we    = clr_busy || s1_wr;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr_r;
  assign ram_wdata = clr_busy ? zbpw_pkg::reset_pixel() : new_pix;

  zbpw_ram #(
    .WIDTH (zbpw_pkg::PIXEL_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Forward the last written pixel over a stale read
  logic              last_valid_r;
  logic [ADDR_W-1:0] last_addr_r;
  zbpw_pkg::pixel_t  last_data_r;
  zbpw_pkg::pixel_t  old_pix;

  assign old_pix = (last_valid_r && (last_addr_r == s1_addr_r)) ?
                   last_data_r : zbpw_pkg::pixel_t'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
    end else if (s1_wr) begin
      last_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      last_addr_r <= s1_addr_r;
      last_data_r <= new_pix;
    end
  end

  // Depth test and merge
  logic pass;

  zbpw_depth_test u_test (
    .op      (s1_op_r),
    .old_pix (old_pix),
    .frag    (s1_frag_r),
    .pass    (pass),
    .new_pix (new_pix)
  );

  logic s1_is_write;
  logic s1_is_read;

  assign s1_is_write = !s1_oor_r && (s1_op_r != zbpw_pkg::OP_READ);
  assign s1_is_read  = !s1_oor_r && (s1_op_r == zbpw_pkg::OP_READ);
  assign s1_wr       = s1_valid_r && s1_adv && s1_is_write && pass;

  // Build the result word
  logic [zbpw_pkg::OUT_DATA_W-1:0] res_word;

  always_comb begin
    res_word       = '0;
    res_word[0]    = s1_oor_r;
    res_word[1]    = s1_is_write && pass;
    if (s1_is_read) begin
      res_word[17:2]  = old_pix.red;
      res_word[33:18] = old_pix.green;
      res_word[49:34] = old_pix.blue;
      res_word[81:50] = old_pix.depth;
      res_word[97:82] = old_pix.owner;
    end
  end

  // Output register
  logic [zbpw_pkg::OUT_DATA_W-1:0] out_data_r;

  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/zbpw_ram.sv -----
module zbpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (returns old data on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/zbpw_addr_gen.sv -----
module zbpw_addr_gen #(
  parameter int MAX_WIDTH  = zbpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbpw_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_W     = 18
) (
  input  logic [zbpw_pkg::COORD_W-1:0] pixel_x,
  input  logic [zbpw_pkg::COORD_W-1:0] pixel_y,
  input  logic [zbpw_pkg::RES_W-1:0]   width_cfg,
  input  logic [zbpw_pkg::RES_W-1:0]   height_cfg,
  output logic                         oor,
  output logic [ADDR_W-1:0]            addr
);

  logic [31:0] w_eff;
  logic [31:0] h_eff;
  logic [31:0] x_mag;
  logic [31:0] y_mag;
  logic [31:0] lin;

  // Cap the resolution in use at the frame size
  assign w_eff = (32'(width_cfg) > 32'(MAX_WIDTH))   ? 32'(MAX_WIDTH)  : 32'(width_cfg);
  assign h_eff = (32'(height_cfg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_cfg);

  assign x_mag = 32'(pixel_x[zbpw_pkg::COORD_W-2:0]);
  assign y_mag = 32'(pixel_y[zbpw_pkg::COORD_W-2:0]);

  // Reject negative or too large coordinates
  assign oor = pixel_x[zbpw_pkg::COORD_W-1] || pixel_y[zbpw_pkg::COORD_W-1] ||
               (x_mag >= w_eff) || (y_mag >= h_eff);

  // Row-major pixel address
  assign lin  = y_mag * w_eff + x_mag;
  assign addr = lin[ADDR_W-1:0];

endmodule

// ----- sv/zbpw_depth_test.sv -----
module zbpw_depth_test (
  input  zbpw_pkg::op_t    op,
  input  zbpw_pkg::pixel_t old_pix,
  input  zbpw_pkg::pixel_t frag,
  output logic             pass,
  output zbpw_pkg::pixel_t new_pix
);

  logic tag_op;
  logic z_pos;
  logic z_near;

  assign tag_op = op inside {zbpw_pkg::OP_TAG, zbpw_pkg::OP_TAG_TEX};

  // Depth must be positive and not farther than the stored depth
  assign z_pos  = ($signed(frag.depth) > 0);
  assign z_near = ($signed(old_pix.depth) >= $signed(frag.depth));

  // With a tag op, the same triangle always overwrites its own pixel
  assign pass = (z_pos && z_near) || (tag_op && (old_pix.owner == frag.owner));

  // Merge the fragment into the stored word
  always_comb begin
    new_pix       = old_pix;
    new_pix.red   = frag.red;
    new_pix.green = frag.green;
    new_pix.blue  = frag.blue;
    new_pix.alpha = frag.alpha;
    new_pix.depth = frag.depth;
    if (tag_op) begin
      new_pix.owner = frag.owner;
      new_pix.kind  = frag.kind;
    end
    if (op == zbpw_pkg::OP_TAG_TEX) begin
      new_pix.texture = frag.texture;
    end
  end

endmodule

// ----- sv/zbpw_clear.sv -----
module zbpw_clear #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              busy,
  output logic [ADDR_W-1:0] addr
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic              busy_r;
  logic              busy_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_nxt;

  // Sweep every entry once after reset
  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

// ----- sv/zbpw_checker.sv -----
module zbpw_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [zbpw_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // Memory clear blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready && !out_tvalid)
    else $error("input taken or result shown right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Rejected access carries nothing else
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[zbpw_pkg::OUT_DATA_W-1:1] == '0)
    else $error("out-of-range result has data");

  // A successful write returns no read data
  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0] &&
      out_tdata[zbpw_pkg::OUT_DATA_W-1:2] == '0)
    else $error("write result carries read data");

endmodule

bind zbuffer_pixel_write_unit zbpw_checker u_zbpw_checker (.*);
